// ----- sv/bpra_pkg.sv -----
// Package: sizes, codes, state type and word-unit structs of the page run allocator.
`default_nettype none
package bpra_pkg;

    localparam int PAGE_TOTAL = 65536;
    localparam int WORD_BITS  = 64;
    localparam int DEPTH      = (PAGE_TOTAL + WORD_BITS - 1) / WORD_BITS;
    localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int PW         = $clog2(PAGE_TOTAL + 1);
    // page arithmetic width: start + count needs 18 bits
    localparam int W          = (PW > 18) ? PW : 18;
    localparam int FC_W       = (PW > 17) ? PW : 17;
    localparam int PC_W       = BIT_W + 1;
    localparam int CHUNK      = 8;
    localparam int CHUNKS     = WORD_BITS / CHUNK;
    localparam int CH_W       = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
    localparam int TAIL       = PAGE_TOTAL % WORD_BITS;
    localparam logic [WORD_BITS-1:0] ONES = {WORD_BITS{1'b1}};
    localparam logic [WORD_BITS-1:0] LAST_VALID =
        (TAIL == 0) ? ONES : (ONES >> (WORD_BITS - TAIL));

    typedef enum logic [1:0] {
        OP_ALLOC     = 2'd0,
        OP_FREE      = 2'd1,
        OP_RESERVE   = 2'd2,
        OP_UNRESERVE = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        STS_OK        = 3'd0,
        STS_NO_RUN    = 3'd1,
        STS_RANGE     = 3'd2,
        STS_RESERVED  = 3'd3,
        STS_NOT_ALLOC = 3'd4,
        STS_EMPTY     = 3'd5
    } t_status;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_EX,
        S_CHUNK,
        S_CHECK_RD,
        S_CHECK_EX,
        S_APPLY_RD,
        S_APPLY_EX,
        S_DONE
    } t_state;

    typedef struct packed {
        t_op                  op;
        logic [WORD_BITS-1:0] res;
        logic [WORD_BITS-1:0] alloc;
        logic [WORD_BITS-1:0] fword;
        logic [WORD_BITS-1:0] vmask;
        logic [WORD_BITS-1:0] mask;
        logic [CH_W-1:0]      chunk;
        logic [W-1:0]         base;
        logic [W-1:0]         run_len;
        logic [W-1:0]         run_start;
        logic [W-1:0]         count;
    } t_wu_in;

    typedef struct packed {
        logic [WORD_BITS-1:0] fword;
        logic                 all_free;
        logic                 none_free;
        logic                 w_found;
        logic [W-1:0]         w_len;
        logic [W-1:0]         w_start;
        logic [W-1:0]         w_end;
        logic                 c_found;
        logic [W-1:0]         c_len;
        logic [W-1:0]         c_start;
        logic [W-1:0]         c_end;
        logic                 bad_any;
        logic                 bad_res;
        logic [WORD_BITS-1:0] new_res;
        logic [WORD_BITS-1:0] new_alloc;
        logic [PC_W-1:0]      pc;
    } t_wu_out;

endpackage
`default_nettype wire

// ----- sv/bpra_if.sv -----
// Interfaces: request and response channels of the page run allocator.
`default_nettype none
interface bpra_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [15:0] start_page;
    logic [16:0] page_count;
    modport source (output valid, output operation, output start_page, output page_count,
                    input ready);
    modport sink (input valid, input operation, input start_page, input page_count,
                  output ready);
endinterface

interface bpra_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [15:0] first_page;
    logic [16:0] free_pages;
    modport source (output valid, output status, output first_page, output free_pages,
                    input ready);
    modport sink (input valid, input status, input first_page, input free_pages,
                  output ready);
endinterface
`default_nettype wire

// ----- sv/bpra_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bpra_ram #(
    parameter int DATA_W = 64,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [DATA_W-1:0] o_rdata
);
    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- sv/bpra_word_unit.sv -----
// Shared word unit: run search, range checks and bitmap updates on one map word.
`default_nettype none
module bpra_word_unit (
    input  wire bpra_pkg::t_wu_in i_wu,
    output bpra_pkg::t_wu_out     o_wu
);
    logic [bpra_pkg::WORD_BITS-1:0] free_w;
    logic [bpra_pkg::WORD_BITS-1:0] bad;
    logic [bpra_pkg::WORD_BITS-1:0] low;
    logic [bpra_pkg::WORD_BITS-1:0] chg;
    logic [bpra_pkg::W-1:0]         wlen;
    logic [bpra_pkg::W-1:0]         wstart;
    logic [bpra_pkg::CHUNK-1:0]     byte_w;
    logic [bpra_pkg::W-1:0]         cofs;
    logic [bpra_pkg::W-1:0]         len;
    logic [bpra_pkg::W-1:0]         st;
    logic [bpra_pkg::W-1:0]         endp;
    logic                           found;

    // whole-word path
    always_comb begin
        free_w = ~i_wu.res & ~i_wu.alloc & i_wu.vmask;
        wstart = (i_wu.run_len == '0) ? i_wu.base : i_wu.run_start;
        wlen   = i_wu.run_len + bpra_pkg::W'(bpra_pkg::WORD_BITS);
    end

    // one chunk of pages of the held free word per pass
    always_comb begin
        byte_w = bpra_pkg::CHUNK'(i_wu.fword >> (bpra_pkg::BIT_W'(i_wu.chunk) *
                                                 bpra_pkg::BIT_W'(bpra_pkg::CHUNK)));
        cofs   = i_wu.base + bpra_pkg::W'(i_wu.chunk) * bpra_pkg::W'(bpra_pkg::CHUNK);
        len    = i_wu.run_len;
        st     = i_wu.run_start;
        endp   = '0;
        found  = 1'b0;
        for (int i = 0; i < bpra_pkg::CHUNK; i++) begin
            if (!found) begin
                if (byte_w[i]) begin
                    if (len == '0) begin
                        st = cofs + bpra_pkg::W'(i);
                    end
                    len = len + 1'b1;
                    if (len == i_wu.count) begin
                        found = 1'b1;
                        endp  = cofs + bpra_pkg::W'(i);
                    end
                end else begin
                    len = '0;
                end
            end
        end
    end

    always_comb begin
        bad = i_wu.mask & (i_wu.res | ~i_wu.alloc);
        low = bad & (~bad + 1'b1);
        chg = '0;
        o_wu.new_res   = i_wu.res;
        o_wu.new_alloc = i_wu.alloc;
        unique case (i_wu.op)
            bpra_pkg::OP_ALLOC: begin
                o_wu.new_alloc = i_wu.alloc | i_wu.mask;
            end
            bpra_pkg::OP_FREE: begin
                o_wu.new_alloc = i_wu.alloc & ~i_wu.mask;
            end
            bpra_pkg::OP_RESERVE: begin
                chg = i_wu.mask & ~i_wu.res & ~i_wu.alloc;
                o_wu.new_res = i_wu.res | i_wu.mask;
            end
            bpra_pkg::OP_UNRESERVE: begin
                chg = i_wu.mask & i_wu.res & ~i_wu.alloc;
                o_wu.new_res = i_wu.res & ~i_wu.mask;
            end
            default: ;
        endcase
        o_wu.pc        = bpra_pkg::PC_W'($countones(chg));
        o_wu.bad_any   = |bad;
        o_wu.bad_res   = |(low & i_wu.res);
        o_wu.fword     = free_w;
        o_wu.all_free  = (free_w == bpra_pkg::ONES);
        o_wu.none_free = (free_w == '0);
        o_wu.w_len     = wlen;
        o_wu.w_start   = wstart;
        o_wu.w_found   = (wlen >= i_wu.count);
        o_wu.w_end     = wstart + i_wu.count - 1'b1;
        o_wu.c_found   = found;
        o_wu.c_len     = len;
        o_wu.c_start   = st;
        o_wu.c_end     = endp;
    end
endmodule
`default_nettype wire

// ----- sv/bitmap_page_run_allocator_unit.sv -----
// Top level: sequencer, bitmap memories and result register of the page run allocator.
//
//  channel  | dir | handshake     | payload
//  i_req    | in  | valid / ready | operation, start_page, page_count
//  o_rsp    | out | valid / ready | status, first_page, free_pages
//
// After reset a clearing pass writes all DEPTH (1024) words of both maps; no transfer is taken.
// Every map word visited passes a read state for the registered RAM read, then an execute state.
// Allocate: scans words, walks a partly used word chunk by chunk, then marks the run's words.
// Free: checks each word of the range, then clears each; reserve, unreserve: apply per word.
// A request is taken only while idle; a finished result holds in DONE while the previous
// one still waits in the output register.
`default_nettype none
module bitmap_page_run_allocator_unit (
    input wire logic  i_clk,
    input wire logic  i_rst_n,
    bpra_req_if.sink   i_req,
    bpra_rsp_if.source o_rsp
);
    bpra_pkg::t_state r_state, n_state;
    bpra_pkg::t_op    r_op, n_op;
    bpra_pkg::t_status r_status, n_status;
    logic [bpra_pkg::W-1:0]         r_count, n_count;
    logic [bpra_pkg::W-1:0]         r_lo, n_lo;
    logic [bpra_pkg::W-1:0]         r_hi, n_hi;
    logic                           r_past, n_past;
    logic [bpra_pkg::ADDR_W-1:0]    r_addr, n_addr;
    logic [bpra_pkg::W-1:0]         r_run_len, n_run_len;
    logic [bpra_pkg::W-1:0]         r_run_start, n_run_start;
    logic [bpra_pkg::CH_W-1:0]      r_chunk, n_chunk;
    logic [bpra_pkg::WORD_BITS-1:0] r_fword, n_fword;
    logic [bpra_pkg::FC_W-1:0]      r_free, n_free;
    logic [bpra_pkg::W-1:0]         r_first, n_first;
    logic                           r_ov, n_ov;
    logic [2:0]                     r_o_status;
    logic [15:0]                    r_o_first;
    logic [16:0]                    r_o_free;
    logic                           load_out;

    logic                           we;
    logic [bpra_pkg::WORD_BITS-1:0] res_wd, alloc_wd, res_rd, alloc_rd;
    bpra_pkg::t_wu_in               wu_in;
    bpra_pkg::t_wu_out              wu_out;

    logic [bpra_pkg::W-1:0]         in_start, in_count, in_end;
    logic [bpra_pkg::ADDR_W-1:0]    lo_w, hi_w;
    logic [bpra_pkg::BIT_W-1:0]     lo_b, hi_b;
    logic                           last_word;

    bpra_ram #(
        .DATA_W (bpra_pkg::WORD_BITS),
        .DEPTH  (bpra_pkg::DEPTH),
        .ADDR_W (bpra_pkg::ADDR_W)
    ) u_res_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_addr),
        .i_wdata (res_wd),
        .i_raddr (r_addr),
        .o_rdata (res_rd)
    );

    bpra_ram #(
        .DATA_W (bpra_pkg::WORD_BITS),
        .DEPTH  (bpra_pkg::DEPTH),
        .ADDR_W (bpra_pkg::ADDR_W)
    ) u_alloc_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_addr),
        .i_wdata (alloc_wd),
        .i_raddr (r_addr),
        .o_rdata (alloc_rd)
    );

    bpra_word_unit u_wu (
        .i_wu (wu_in),
        .o_wu (wu_out)
    );

    always_comb begin
        in_start  = bpra_pkg::W'(i_req.start_page);
        in_count  = bpra_pkg::W'(i_req.page_count);
        in_end    = in_start + in_count;
        lo_w      = r_lo[bpra_pkg::BIT_W +: bpra_pkg::ADDR_W];
        hi_w      = r_hi[bpra_pkg::BIT_W +: bpra_pkg::ADDR_W];
        lo_b      = (r_addr == lo_w) ? r_lo[bpra_pkg::BIT_W-1:0] : '0;
        hi_b      = (r_addr == hi_w) ? r_hi[bpra_pkg::BIT_W-1:0]
                                     : bpra_pkg::BIT_W'(bpra_pkg::WORD_BITS - 1);
        last_word = (r_addr == bpra_pkg::ADDR_W'(bpra_pkg::DEPTH - 1));

        wu_in.op        = r_op;
        wu_in.res       = res_rd;
        wu_in.alloc     = alloc_rd;
        wu_in.fword     = r_fword;
        wu_in.vmask     = last_word ? bpra_pkg::LAST_VALID : bpra_pkg::ONES;
        wu_in.mask      = (bpra_pkg::ONES << lo_b) &
                          (bpra_pkg::ONES >> (bpra_pkg::BIT_W'(bpra_pkg::WORD_BITS - 1) - hi_b));
        wu_in.chunk     = r_chunk;
        wu_in.base      = bpra_pkg::W'({r_addr, {bpra_pkg::BIT_W{1'b0}}});
        wu_in.run_len   = r_run_len;
        wu_in.run_start = r_run_start;
        wu_in.count     = r_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bpra_pkg::S_CLEAR;
            r_addr  <= '0;
            r_free  <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_free  <= n_free;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_status    <= n_status;
        r_count     <= n_count;
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_past      <= n_past;
        r_run_len   <= n_run_len;
        r_run_start <= n_run_start;
        r_chunk     <= n_chunk;
        r_fword     <= n_fword;
        r_first     <= n_first;
        if (load_out) begin
            r_o_status <= r_status;
            r_o_first  <= r_first[15:0];
            r_o_free   <= r_free[16:0];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_status    = r_status;
        n_count     = r_count;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_past      = r_past;
        n_addr      = r_addr;
        n_run_len   = r_run_len;
        n_run_start = r_run_start;
        n_chunk     = r_chunk;
        n_fword     = r_fword;
        n_free      = r_free;
        n_first     = r_first;
        n_ov        = r_ov && !o_rsp.ready;
        load_out    = 1'b0;
        we          = 1'b0;
        res_wd      = wu_out.new_res;
        alloc_wd    = wu_out.new_alloc;
        i_req.ready = (r_state == bpra_pkg::S_IDLE);

        unique case (r_state)
            bpra_pkg::S_CLEAR: begin
                we       = 1'b1;
                res_wd   = bpra_pkg::ONES;
                alloc_wd = '0;
                if (last_word) begin
                    n_state = bpra_pkg::S_IDLE;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            bpra_pkg::S_IDLE: begin
                if (i_req.valid) begin
                    n_op        = bpra_pkg::t_op'(i_req.operation);
                    n_count     = in_count;
                    n_first     = '0;
                    n_run_len   = '0;
                    n_run_start = '0;
                    n_lo        = in_start;
                    n_past      = (in_end > bpra_pkg::W'(bpra_pkg::PAGE_TOTAL));
                    n_hi        = n_past ? bpra_pkg::W'(bpra_pkg::PAGE_TOTAL - 1)
                                         : in_end - 1'b1;
                    n_addr      = in_start[bpra_pkg::BIT_W +: bpra_pkg::ADDR_W];
                    n_status    = bpra_pkg::STS_OK;
                    priority if (in_count == '0) begin
                        n_status = bpra_pkg::STS_EMPTY;
                        n_state  = bpra_pkg::S_DONE;
                    end else if (n_op == bpra_pkg::OP_ALLOC) begin
                        n_addr = '0;
                        if (in_count > bpra_pkg::W'(bpra_pkg::PAGE_TOTAL)) begin
                            n_status = bpra_pkg::STS_NO_RUN;
                            n_state  = bpra_pkg::S_DONE;
                        end else begin
                            n_state = bpra_pkg::S_SCAN_RD;
                        end
                    end else if (n_op == bpra_pkg::OP_FREE) begin
                        if (in_start >= bpra_pkg::W'(bpra_pkg::PAGE_TOTAL)) begin
                            n_status = bpra_pkg::STS_RANGE;
                            n_state  = bpra_pkg::S_DONE;
                        end else begin
                            n_state = bpra_pkg::S_CHECK_RD;
                        end
                    end else begin
                        if (n_past) begin
                            n_status = bpra_pkg::STS_RANGE;
                            n_state  = bpra_pkg::S_DONE;
                        end else begin
                            n_state = bpra_pkg::S_APPLY_RD;
                        end
                    end
                end
            end
            bpra_pkg::S_SCAN_RD: begin
                n_state = bpra_pkg::S_SCAN_EX;
            end
            bpra_pkg::S_SCAN_EX: begin
                priority if (wu_out.all_free) begin
                    if (wu_out.w_found) begin
                        n_lo    = wu_out.w_start;
                        n_hi    = wu_out.w_end;
                        n_addr  = wu_out.w_start[bpra_pkg::BIT_W +: bpra_pkg::ADDR_W];
                        n_state = bpra_pkg::S_APPLY_RD;
                    end else begin
                        n_run_len   = wu_out.w_len;
                        n_run_start = wu_out.w_start;
                        n_state     = last_word ? bpra_pkg::S_DONE : bpra_pkg::S_SCAN_RD;
                        n_status    = last_word ? bpra_pkg::STS_NO_RUN : r_status;
                        n_addr      = last_word ? r_addr : r_addr + 1'b1;
                    end
                end else if (wu_out.none_free) begin
                    n_run_len = '0;
                    n_state   = last_word ? bpra_pkg::S_DONE : bpra_pkg::S_SCAN_RD;
                    n_status  = last_word ? bpra_pkg::STS_NO_RUN : r_status;
                    n_addr    = last_word ? r_addr : r_addr + 1'b1;
                end else begin
                    n_fword = wu_out.fword;
                    n_chunk = '0;
                    n_state = bpra_pkg::S_CHUNK;
                end
            end
            bpra_pkg::S_CHUNK: begin
                n_run_len   = wu_out.c_len;
                n_run_start = wu_out.c_start;
                if (wu_out.c_found) begin
                    n_lo    = wu_out.c_start;
                    n_hi    = wu_out.c_end;
                    n_addr  = wu_out.c_start[bpra_pkg::BIT_W +: bpra_pkg::ADDR_W];
                    n_state = bpra_pkg::S_APPLY_RD;
                end else if (r_chunk == bpra_pkg::CH_W'(bpra_pkg::CHUNKS - 1)) begin
                    n_state  = last_word ? bpra_pkg::S_DONE : bpra_pkg::S_SCAN_RD;
                    n_status = last_word ? bpra_pkg::STS_NO_RUN : r_status;
                    n_addr   = last_word ? r_addr : r_addr + 1'b1;
                end else begin
                    n_chunk = r_chunk + 1'b1;
                end
            end
            bpra_pkg::S_CHECK_RD: begin
                n_state = bpra_pkg::S_CHECK_EX;
            end
            bpra_pkg::S_CHECK_EX: begin
                // first failing page in ascending order decides the status
                priority if (wu_out.bad_any) begin
                    n_status = wu_out.bad_res ? bpra_pkg::STS_RESERVED
                                              : bpra_pkg::STS_NOT_ALLOC;
                    n_state  = bpra_pkg::S_DONE;
                end else if (r_addr == hi_w) begin
                    if (r_past) begin
                        n_status = bpra_pkg::STS_RANGE;
                        n_state  = bpra_pkg::S_DONE;
                    end else begin
                        n_addr  = lo_w;
                        n_state = bpra_pkg::S_APPLY_RD;
                    end
                end else begin
                    n_addr  = r_addr + 1'b1;
                    n_state = bpra_pkg::S_CHECK_RD;
                end
            end
            bpra_pkg::S_APPLY_RD: begin
                n_state = bpra_pkg::S_APPLY_EX;
            end
            bpra_pkg::S_APPLY_EX: begin
                we = 1'b1;
                unique case (r_op)
                    bpra_pkg::OP_RESERVE:
                        n_free = r_free - bpra_pkg::FC_W'(wu_out.pc);
                    bpra_pkg::OP_UNRESERVE:
                        n_free = r_free + bpra_pkg::FC_W'(wu_out.pc);
                    default: ;
                endcase
                if (r_addr == hi_w) begin
                    n_state  = bpra_pkg::S_DONE;
                    n_status = bpra_pkg::STS_OK;
                    if (r_op == bpra_pkg::OP_ALLOC) begin
                        n_free  = r_free - bpra_pkg::FC_W'(r_count);
                        n_first = r_lo;
                    end else if (r_op == bpra_pkg::OP_FREE) begin
                        n_free = r_free + bpra_pkg::FC_W'(r_count);
                    end
                end else begin
                    n_addr  = r_addr + 1'b1;
                    n_state = bpra_pkg::S_APPLY_RD;
                end
            end
            bpra_pkg::S_DONE: begin
                if (!r_ov || o_rsp.ready) begin
                    load_out = 1'b1;
                    n_ov     = 1'b1;
                    n_state  = bpra_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bpra_pkg::S_IDLE;
            end
        endcase
    end

    assign o_rsp.valid      = r_ov;
    assign o_rsp.status     = r_o_status;
    assign o_rsp.first_page = r_o_first;
    assign o_rsp.free_pages = r_o_free;

    a_empty_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready && i_req.page_count == 17'd0) |=>
        (r_state == bpra_pkg::S_DONE && r_status == bpra_pkg::STS_EMPTY))
        else $error("empty request did not finish at once");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bpra_pkg::S_IDLE || r_state == bpra_pkg::S_DONE) |-> !we)
        else $error("map write outside an update pass");

    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free <= bpra_pkg::FC_W'(bpra_pkg::PAGE_TOTAL))
        else $error("free counter above page total");

    a_rsp_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp.valid) |-> $past(r_state == bpra_pkg::S_DONE))
        else $error("response raised outside completion");
endmodule
`default_nettype wire
